/* rtl/ckph_pkg.sv */
// Shared types, constants and the hash function of the coordinate-keyed hash map.
package ckph_pkg;

	// Default table size and load limit (an insert may not push the count past SLOTS / 2).
	localparam int DEF_TABLE_SLOTS = 1024;
	localparam int LOAD_DIVISOR    = 2;

	// Fixed field widths.
	localparam int COORD_W = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int KEY_W   = 3 * COORD_W;
	localparam int HASH_W  = 16;

	// Operation codes.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_HASH3,
		ST_PROBE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic load;
		logic start;
		logic step;
		logic finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic neg_get;
		logic stop;
	} ctl_sts_t;

	// XOR-fold of the three raw coordinate patterns: x ^ rotl(y, 5) ^ rotl(z, 10).
	function automatic logic [HASH_W-1:0] fold_hash(
		input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z
	);
		return x ^ {y[10:0], y[15:11]} ^ {z[5:0], z[15:6]};
	endfunction

endpackage

/* rtl/ckph_if.sv */
// Request and response channel interfaces of the coordinate-keyed hash map.
interface ckph_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  op;
	logic signed [ckph_pkg::COORD_W-1:0]   coord_x;
	logic signed [ckph_pkg::COORD_W-1:0]   coord_y;
	logic signed [ckph_pkg::COORD_W-1:0]   coord_z;
	logic        [ckph_pkg::VALUE_W-1:0]   item_value;

	modport source(output valid, op, coord_x, coord_y, coord_z, item_value, input ready);
	modport sink(input valid, op, coord_x, coord_y, coord_z, item_value, output ready);
endinterface

interface ckph_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ckph_pkg::VALUE_W-1:0]  found_value;
	logic                          changed;
	logic                          table_full;
	logic [ckph_pkg::COUNT_W-1:0]  entry_count;

	modport source(output valid, found_value, changed, table_full, entry_count, input ready);
	modport sink(input valid, found_value, changed, table_full, entry_count, output ready);
endinterface

/* rtl/ckph_ctrl.sv */
// Controller state machine: clearing pass, hash sequencing, probe loop and output handshake.
module ckph_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ckph_pkg::ctl_sts_t sts,
	output ckph_pkg::ctl_cmd_t cmd
);

	ckph_pkg::state_t state_q;
	ckph_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ckph_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = ckph_pkg::ST_IDLE;
			end
			ckph_pkg::ST_IDLE: begin
				if (in_valid) state_d = ckph_pkg::ST_HASH1;
			end
			ckph_pkg::ST_HASH1: begin
				state_d = ckph_pkg::ST_HASH2;
			end
			ckph_pkg::ST_HASH2: begin
				state_d = ckph_pkg::ST_HASH3;
			end
			ckph_pkg::ST_HASH3: begin
				if (!sts.neg_get) state_d = ckph_pkg::ST_PROBE;
				else if (out_free) state_d = ckph_pkg::ST_IDLE;
			end
			ckph_pkg::ST_PROBE: begin
				if (sts.stop && out_free) state_d = ckph_pkg::ST_IDLE;
			end
			default: begin
				state_d = ckph_pkg::ST_CLEAR;
			end
		endcase
	end

	// Commands for the datapath.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ckph_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ckph_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ckph_pkg::ST_HASH3: begin
				cmd.start  = !sts.neg_get;
				cmd.finish = sts.neg_get && out_free;
			end
			ckph_pkg::ST_PROBE: begin
				cmd.step   = !sts.stop;
				cmd.finish = sts.stop && out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ckph_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/ckph_dpath.sv */
// Datapath: item registers, home-slot pipeline, slot memories, probe logic and result register.
module ckph_dpath #(
	parameter int TABLE_SLOTS = ckph_pkg::DEF_TABLE_SLOTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ckph_pkg::ctl_cmd_t                  cmd,
	output ckph_pkg::ctl_sts_t                  sts,
	input  logic                                op,
	input  logic signed [ckph_pkg::COORD_W-1:0] coord_x,
	input  logic signed [ckph_pkg::COORD_W-1:0] coord_y,
	input  logic signed [ckph_pkg::COORD_W-1:0] coord_z,
	input  logic        [ckph_pkg::VALUE_W-1:0] item_value,
	output logic        [ckph_pkg::VALUE_W-1:0] found_value,
	output logic                                changed,
	output logic                                table_full,
	output logic        [ckph_pkg::COUNT_W-1:0] entry_count
);

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS / 2 + 1);
	localparam int HW = ckph_pkg::HASH_W;
	// Reciprocal of the slot count, scaled by 2^32 and rounded up; exact for 16-bit hashes.
	localparam logic [31:0] RECIP =
		32'(((64'd1 << 32) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
	localparam logic [HW:0]   SLOTS_V = (HW + 1)'(TABLE_SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

	// Item registers.
	logic                            op_q;
	logic [ckph_pkg::KEY_W-1:0]      key_q;
	logic [ckph_pkg::VALUE_W-1:0]    val_q;
	logic                            neg_q;

	// Home-slot pipeline.
	logic [HW-1:0]    hash;
	logic [HW-1:0]    h_s2;
	logic [HW-1:0]    h_s3;
	logic [47:0]      prod1_s2;
	logic [2*HW:0]    prod2_s3;
	logic [HW:0]      home_r;
	logic [IW-1:0]    home_idx;

	// Probe state and memories.
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                idx_next;
	logic [IW-1:0]                rd_addr;
	logic [IW-1:0]                cnt_q;
	logic [IW-1:0]                clr_q;
	logic [ckph_pkg::KEY_W-1:0]   key_mem [TABLE_SLOTS];
	logic [ckph_pkg::VALUE_W-1:0] val_mem [TABLE_SLOTS];
	logic [ckph_pkg::KEY_W-1:0]   rd_key_q;
	logic [ckph_pkg::VALUE_W-1:0] rd_val_q;

	// Decision signals.
	logic                         is_set;
	logic                         hole;
	logic                         hit;
	logic                         exhausted;
	logic [17:0]                  need;
	logic                         room;
	logic                         upd;
	logic                         ins;
	logic                         full;
	logic                         key_we;
	logic                         val_we;
	logic [IW-1:0]                val_waddr;
	logic [ckph_pkg::VALUE_W-1:0] val_wdata;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_next;
	logic [CW+ckph_pkg::COUNT_W-1:0] count_ext;

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= {coord_z, coord_y, coord_x};
			val_q <= item_value;
			neg_q <= coord_x[ckph_pkg::COORD_W-1] | coord_y[ckph_pkg::COORD_W-1]
				| coord_z[ckph_pkg::COORD_W-1];
		end
	end

	// Home slot = hash mod TABLE_SLOTS via reciprocal multiply, one product per stage.
	assign hash = ckph_pkg::fold_hash(key_q[15:0], key_q[31:16], key_q[47:32]);

	always_ff @(posedge clk) begin
		prod1_s2 <= 48'(hash) * 48'(RECIP);
		h_s2     <= hash;
		prod2_s3 <= (2*HW + 1)'(prod1_s2[47:32]) * (2*HW + 1)'(SLOTS_V);
		h_s3     <= h_s2;
	end

	assign home_r   = {1'b0, h_s3} - prod2_s3[HW:0];
	assign home_idx = home_r[IW-1:0];

	// Read address: home slot on start, next slot on a step, else hold.
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);

	always_comb begin
		if (cmd.start) begin
			rd_addr = home_idx;
		end else if (cmd.step) begin
			rd_addr = idx_next;
		end else begin
			rd_addr = idx_q;
		end
	end

	// Probe position and probe count.
	always_ff @(posedge clk) begin
		idx_q <= rd_addr;
		if (cmd.start) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + IW'(1);
		end
	end

	// Evaluate the slot just read.
	assign is_set    = (op_q == ckph_pkg::OP_SET);
	assign hole      = (rd_val_q == '0);
	assign hit       = !hole && (rd_key_q == key_q);
	assign exhausted = (cnt_q == LAST_IDX);
	assign need      = (18'(count_q) + 18'd1) * 18'(ckph_pkg::LOAD_DIVISOR);
	assign room      = (need <= 18'(TABLE_SLOTS));
	assign upd       = is_set && hit && (rd_val_q != val_q);
	assign ins       = is_set && !hit && (val_q != '0) && hole && room;
	assign full      = is_set && !hit && (val_q != '0) && !(hole && room);

	assign sts.stop     = hit || hole || exhausted;
	assign sts.neg_get  = !is_set && neg_q;
	assign sts.clr_last = (clr_q == LAST_IDX);

	// Memory write controls: the clearing pass empties values, a finish commits the store.
	assign key_we    = cmd.finish && ins;
	assign val_we    = cmd.clr_step || (cmd.finish && (upd || ins));
	assign val_waddr = cmd.clr_step ? clr_q : idx_q;
	assign val_wdata = cmd.clr_step ? '0 : val_q;

	// Key memory.
	always_ff @(posedge clk) begin
		if (key_we) key_mem[idx_q] <= key_q;
		rd_key_q <= key_mem[rd_addr];
	end

	// Value memory.
	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_waddr] <= val_wdata;
		rd_val_q <= val_mem[rd_addr];
	end

	// Entry count and clearing-pass address.
	assign count_next = ins ? count_q + CW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.finish) count_q <= count_next;
			if (cmd.clr_step) clr_q <= clr_q + IW'(1);
		end
	end

	assign count_ext = (CW + ckph_pkg::COUNT_W)'(count_next);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_value <= (!is_set && !neg_q && hit) ? rd_val_q : '0;
			changed     <= upd || ins;
			table_full  <= full;
			entry_count <= count_ext[ckph_pkg::COUNT_W-1:0];
		end
	end

endmodule

/* rtl/coord_keyed_probe_hash_map.sv */
// Top level of the coordinate-keyed linear-probing hash map.
//
//  channel  role    payload
//  req      sink    op, coord_x, coord_y, coord_z, item_value
//  rsp      source  found_value, changed, table_full, entry_count
//
// An item passes the idle state, the hash states HASH1, HASH2 and HASH3 (home-slot arithmetic,
// two registered multiplies), then one memory read per probed slot, with 1 to TABLE_SLOTS
// slots read; a new item is taken only in the idle state, once the last one has finished.
// A lookup with a negative coordinate reads no slot. After reset a clearing pass empties
// the value memory while req.ready stays low. A result waits in the output register while
// the next item is taken; a finished probe holds until that register is free.
module coord_keyed_probe_hash_map #(
	parameter int TABLE_SLOTS = ckph_pkg::DEF_TABLE_SLOTS
) (
	input logic         clk,
	input logic         arst_n,
	ckph_req_if.sink    req,
	ckph_rsp_if.source  rsp
);

	ckph_pkg::ctl_cmd_t cmd;
	ckph_pkg::ctl_sts_t sts;

	// Sequencing and handshakes.
	ckph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Slot storage and probe arithmetic.
	ckph_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (req.op),
		.coord_x     (req.coord_x),
		.coord_y     (req.coord_y),
		.coord_z     (req.coord_z),
		.item_value  (req.item_value),
		.found_value (rsp.found_value),
		.changed     (rsp.changed),
		.table_full  (rsp.table_full),
		.entry_count (rsp.entry_count)
	);

endmodule
